// File: sv/fifoq_pkg.sv
// ----------------------------------------------------------------------------
// fifoq_pkg
// Shared types and codes for the queue with a writable front entry.
// ----------------------------------------------------------------------------
package fifoq_pkg;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

  // status codes on the result channel
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // operation as classified by the front part
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_MODIFY,
    OP_DUMP
  } op_t;

  // request passed from front to back
  typedef struct packed {
    op_t              op;
    logic [DATA_W-1:0] value;
  } req_t;

endpackage

// File: sv/fifoq_front.sv
// ----------------------------------------------------------------------------
// fifoq_front
// Accepts command requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module fifoq_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fifoq_pkg::DATA_W-1:0] in_value,
  input  logic [fifoq_pkg::CMD_W-1:0]  in_cmd,
  output logic                       req_valid,
  input  logic                       req_ready,
  output fifoq_pkg::req_t            req
);

  localparam int Q_DEPTH = 2;

  fifoq_pkg::op_t              q_op_r  [Q_DEPTH];
  logic [fifoq_pkg::DATA_W-1:0] q_val_r [Q_DEPTH];
  logic                        wr_ptr_r, wr_ptr_nxt;
  logic                        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                  cnt_r, cnt_nxt;
  fifoq_pkg::op_t              op_class;
  logic                        push_q;
  logic                        pop_q;

  // classify the command code
  always_comb begin
    case (in_cmd)
      fifoq_pkg::CMD_PUSH:   op_class = fifoq_pkg::OP_PUSH;
      fifoq_pkg::CMD_POP:    op_class = fifoq_pkg::OP_POP;
      fifoq_pkg::CMD_MODIFY: op_class = fifoq_pkg::OP_MODIFY;
      fifoq_pkg::CMD_DUMP:   op_class = fifoq_pkg::OP_DUMP;
      default:               op_class = fifoq_pkg::OP_DUMP;
    endcase
  end

  // queue handshakes
  assign in_tready = (cnt_r != 2'(Q_DEPTH));
  assign req_valid = (cnt_r != 2'd0);
  assign push_q    = in_tvalid && in_tready;
  assign pop_q     = req_valid && req_ready;

  assign req.op    = q_op_r[rd_ptr_r];
  assign req.value = q_val_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push_q ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_q ? ~rd_ptr_r : rd_ptr_r;
    case ({push_q, pop_q})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue slots
  always_ff @(posedge clk) begin
    if (push_q) begin
      q_op_r[wr_ptr_r]  <= op_class;
      q_val_r[wr_ptr_r] <= in_value;
    end
  end

endmodule

// File: sv/fifoq_back.sv
// ----------------------------------------------------------------------------
// fifoq_back
// Ring buffer store and the sequencer that carries out queued requests.
// ----------------------------------------------------------------------------
module fifoq_back #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  fifoq_pkg::req_t               req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fifoq_pkg::DATA_W-1:0]   out_word,
  output logic [fifoq_pkg::STATUS_W-1:0] out_status,
  output logic [fifoq_pkg::OCC_W-1:0]    out_occ,
  output logic                          out_last
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_t;

  // entry store
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [WORD_BITS-1:0] wr_data;
  logic [fifoq_pkg::DATA_W-1:0] rd_word;
  logic                 mem_we;
  logic                 mem_re;
  logic [PTR_W-1:0]     wr_addr;
  logic [PTR_W-1:0]     rd_addr;

  // control state
  state_t               state_r, state_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [PTR_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     remain_r, remain_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [fifoq_pkg::DATA_W-1:0]   out_word_r, out_word_nxt;
  logic [fifoq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [fifoq_pkg::OCC_W-1:0]    out_occ_r, out_occ_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_free;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // word width adaption on write and read
  generate
    if (WORD_BITS >= fifoq_pkg::DATA_W) begin : g_wide
      assign wr_data = WORD_BITS'(req.value);
      assign rd_word = rd_data_r[fifoq_pkg::DATA_W-1:0];
    end else begin : g_narrow
      assign wr_data = req.value[WORD_BITS-1:0];
      assign rd_word = {{(fifoq_pkg::DATA_W - WORD_BITS){1'b0}}, rd_data_r};
    end
  endgenerate

  assign out_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    remain_nxt     = remain_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    req_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    wr_addr        = tail_r;
    rd_addr        = head_r;

    case (state_r)
      S_IDLE: begin
        if (req_valid && out_free) begin
          req_ready      = 1'b1;
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_occ_nxt    = fifoq_pkg::OCC_W'(count_r);
          out_status_nxt = fifoq_pkg::ST_OK;
          case (req.op)
            fifoq_pkg::OP_PUSH: begin
              if (count_r == CNT_W'(DEPTH)) begin
                out_status_nxt = fifoq_pkg::ST_FULL;
              end else begin
                mem_we      = 1'b1;
                wr_addr     = tail_r;
                tail_nxt    = next_slot(tail_r);
                count_nxt   = count_r + CNT_W'(1);
                out_occ_nxt = fifoq_pkg::OCC_W'(count_nxt);
              end
            end
            fifoq_pkg::OP_POP: begin
              if (count_r == '0) begin
                out_status_nxt = fifoq_pkg::ST_EMPTY;
              end else begin
                // result waits in S_POP for the registered read data
                out_valid_nxt = 1'b0;
                mem_re        = 1'b1;
                rd_addr       = head_r;
                head_nxt      = next_slot(head_r);
                count_nxt     = count_r - CNT_W'(1);
                state_nxt     = S_POP;
              end
            end
            fifoq_pkg::OP_MODIFY: begin
              if (count_r == '0) begin
                out_status_nxt = fifoq_pkg::ST_EMPTY;
              end else begin
                mem_we  = 1'b1;
                wr_addr = head_r;
              end
            end
            fifoq_pkg::OP_DUMP: begin
              if (count_r == '0) begin
                out_status_nxt = fifoq_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                mem_re        = 1'b1;
                rd_addr       = head_r;
                idx_nxt       = next_slot(head_r);
                remain_nxt    = count_r;
                state_nxt     = S_DUMP;
              end
            end
            default: begin
              out_status_nxt = fifoq_pkg::ST_EMPTY;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = rd_word;
          out_status_nxt = fifoq_pkg::ST_OK;
          out_occ_nxt    = fifoq_pkg::OCC_W'(count_r);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DUMP: begin
        // one entry per cycle while the result register is free, next read issued as the current one leaves
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = rd_word;
          out_status_nxt = fifoq_pkg::ST_OK;
          out_occ_nxt    = fifoq_pkg::OCC_W'(count_r);
          out_last_nxt   = (remain_r == CNT_W'(1));
          if (remain_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re     = 1'b1;
            rd_addr    = idx_r;
            idx_nxt    = next_slot(idx_r);
            remain_nxt = remain_r - CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  // entry store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign out_status = out_status_r;
  assign out_occ    = out_occ_r;
  assign out_last   = out_last_r;

endmodule

// File: sv/fifo_queue_with_front_modify.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_front_modify
// Bounded FIFO of words with push, pop, overwrite-front and dump commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  carries one command request: in_tuser holds the command code
//         (push, pop, overwrite oldest, dump), in_tdata the 32-bit value.
//   out_* carries result requests: word and occupancy in out_tdata, status
//         in out_tuser, out_tlast on the final result of a command.
// A push, overwrite or any empty/full result goes from the command queue
//   through the sequencer into the result register; a pop result and the
//   first dump entry also pass the registered read of the entry store.
// The sequencer handles a push or overwrite in its idle state alone; a pop
//   also passes the pop state, and a dump stays in the dump state until its
//   last entry, taking no new command meanwhile. The sequencer and the
//   single read port of the entry store set this order.
// A two-entry command queue lets new requests in while the sequencer works.
// Reset empties the queue (head, tail and count cleared); stored words are
//   not cleared and are never read before being written.
// When out_tready is low while a result is held, the result register holds
//   and the sequencer waits; the command queue keeps taking input until it is full.
// ----------------------------------------------------------------------------
module fifo_queue_with_front_modify #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] word, [38:32] occupancy, [39] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  logic                          req_valid;
  logic                          req_ready;
  fifoq_pkg::req_t               req;
  logic [fifoq_pkg::DATA_W-1:0]   res_word;
  logic [fifoq_pkg::OCC_W-1:0]    res_occ;

  // front: accept and classify
  fifoq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_value  (in_tdata),
    .in_cmd    (in_tuser),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  // back: store and sequencer
  fifoq_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_word   (res_word),
    .out_status (out_tuser),
    .out_occ    (res_occ),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, res_occ, res_word};

endmodule
